// File: hdl/srpg_pkg.sv
// Shared types and constants of the stepper ramp pulse generator.
// Used by the divider, datapath, controller and top level; no dependencies.
package srpg_pkg;

	// Motion modes as seen on the result stream.
	localparam logic [1:0] MODE_STOPPED = 2'd0;
	localparam logic [1:0] MODE_ACCEL   = 2'd1;
	localparam logic [1:0] MODE_RUN     = 2'd2;
	localparam logic [1:0] MODE_DECEL   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_PERIOD = 2'd0;
	localparam logic [1:0] REG_RAMP_PULSES  = 2'd1;
	localparam logic [1:0] REG_REVERSE      = 2'd2;

	// Configuration reset values.
	localparam logic [15:0] START_PERIOD_RST = 16'd2000;
	localparam logic [11:0] RAMP_PULSES_RST  = 12'd200;
	localparam logic [31:0] REVERSE_RST      = 32'd0;

	// Field widths.
	localparam int PERIOD_W = 16;
	localparam int RAMP_W   = 12;
	localparam int REV_W    = 32;
	localparam int POS_W    = 18;   // signed current half-period
	localparam int STEP_W   = 17;   // signed ramp step
	localparam int DIVA_W   = 19;   // signed dividend of the ramp step division
	localparam int MAG_W    = 18;   // dividend magnitude, one quotient bit per cycle
	localparam int CNT_W    = 5;

	// One result item, step_level in the lowest bit.
	typedef struct packed {
		logic [1:0] motion_mode;
		logic       driver_on;
		logic       direction_level;
		logic       step_level;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic rev_upd;
		logic div_start;
		logic upd;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_done;
	} stat_t;

endpackage

// File: hdl/srpg_div.sv
// Iterative signed-by-unsigned divider for the ramp step size.
// Gives clamp(trunc(a / d) + 1) one quotient bit per cycle; uses srpg_pkg.
module srpg_div
	import srpg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIVA_W-1:0] dividend,
	input  logic [RAMP_W-1:0]        divisor,
	output logic                     done,
	output logic signed [STEP_W-1:0] result
);

	logic                     busy_q;
	logic                     fin_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         mag_q;
	logic [RAMP_W-1:0]        rem_q;
	logic [RAMP_W-1:0]        div_q;
	logic signed [STEP_W-1:0] res_q;

	logic [DIVA_W-1:0]        a_abs;
	logic [RAMP_W:0]          shifted;
	logic                     qbit;
	logic [RAMP_W:0]          rem_next;
	logic signed [MAG_W+1:0]  q_signed;
	logic signed [MAG_W+1:0]  q_plus;
	logic signed [STEP_W-1:0] q_clamped;

	// Magnitude of the dividend; it never exceeds 18 bits.
	assign a_abs = dividend[DIVA_W-1] ? (~dividend + 1'b1) : dividend;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	assign shifted  = {rem_q, mag_q[MAG_W-1]};
	assign qbit     = (shifted >= {1'b0, div_q});
	assign rem_next = qbit ? (shifted - {1'b0, div_q}) : shifted;

	// Apply the sign, add one and clamp into the step range.
	always_comb begin
		q_signed = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
		q_plus   = q_signed + 20'sd1;
		if (q_plus < -20'sd65536) begin
			q_clamped = -17'sd65536;
		end else if (q_plus > 20'sd65535) begin
			q_clamped = 17'sd65535;
		end else begin
			q_clamped = q_plus[STEP_W-1:0];
		end
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
		end
	end

	// Operand, partial remainder and result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIVA_W-1];
			mag_q <= a_abs[MAG_W-1:0];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-2:0], qbit};
			rem_q <= rem_next[RAMP_W-1:0];
		end
		if (fin_q) begin
			res_q <= q_clamped;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hdl/srpg_dp.sv
// Datapath of the stepper ramp pulse generator: configuration, motion state,
// half-period timer and ramp arithmetic. Uses srpg_pkg and srpg_div.
module srpg_dp
	import srpg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [23:0]         in_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata,
	output res_t                res
);

	// Configuration registers.
	logic [PERIOD_W-1:0] start_q;
	logic [RAMP_W-1:0]   ramp_q;
	logic [REV_W-1:0]    revint_q;

	// Latched request.
	logic                run_q;
	logic                dir_in_q;
	logic [PERIOD_W-1:0] target_q;

	// Motion state.
	logic [1:0]               mode_q;
	logic signed [POS_W-1:0]  period_q;
	logic signed [STEP_W-1:0] step_q;
	logic [RAMP_W-1:0]        rcount_q;
	logic [PERIOD_W-1:0]      tick_q;
	logic                     pulse_q;
	logic                     dir_now_q;
	logic [REV_W-1:0]         rev_q;
	logic                     want_q;

	logic [RAMP_W-1:0]        ramp_len;
	logic signed [DIVA_W-1:0] div_a;
	logic                     div_done;
	logic signed [STEP_W-1:0] div_res;
	logic signed [POS_W-1:0]  tsrc;
	logic [PERIOD_W:0]        tdiv;
	logic [PERIOD_W:0]        tick_inc;
	logic                     toggle;
	logic [RAMP_W:0]          ramp_inc;
	logic                     ramp_end;
	logic signed [DIVA_W-1:0] step_ext;
	logic signed [DIVA_W-1:0] addend;
	logic signed [DIVA_W-1:0] sum;
	logic signed [POS_W-1:0]  period_sat;
	logic                     leave_run;
	logic [REV_W:0]           rev_inc;

	assign ramp_len = (ramp_q == '0) ? RAMP_W'(1) : ramp_q;

	// Dividend: start minus target on a start, start minus current period on a stop.
	assign div_a = $signed({3'b000, start_q}) - ((mode_q == MODE_STOPPED)
		? $signed({3'b000, target_q}) : $signed({period_q[POS_W-1], period_q}));

	srpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (ramp_len),
		.done     (div_done),
		.result   (div_res)
	);

	// Half-period timer, limited to 1..65536 ticks.
	always_comb begin
		tsrc = (mode_q == MODE_RUN) ? $signed({2'b00, target_q}) : period_q;
		if (tsrc < 18'sd1) begin
			tdiv = 17'd1;
		end else if (tsrc > 18'sd65536) begin
			tdiv = 17'd65536;
		end else begin
			tdiv = tsrc[PERIOD_W:0];
		end
	end
	assign tick_inc = {1'b0, tick_q} + 1'b1;
	assign toggle   = (tick_inc >= tdiv);

	// Ramp toggle count and saturated period adjustment.
	assign ramp_inc = {1'b0, rcount_q} + 1'b1;
	assign ramp_end = (ramp_inc >= {1'b0, ramp_len});
	assign step_ext = {{2{step_q[STEP_W-1]}}, step_q};
	assign addend   = (mode_q == MODE_ACCEL) ? -step_ext : step_ext;
	assign sum      = {period_q[POS_W-1], period_q} + addend;
	always_comb begin
		if (sum[DIVA_W-1] != sum[DIVA_W-2]) begin
			period_sat = sum[DIVA_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
				: {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			period_sat = sum[POS_W-1:0];
		end
	end

	assign leave_run     = !run_q || (want_q != dir_now_q);
	assign stat.need_div = ((mode_q == MODE_STOPPED) && run_q)
		|| ((mode_q == MODE_RUN) && leave_run);
	assign stat.div_done = div_done;

	assign rev_inc = {1'b0, rev_q} + 1'b1;

	// Latched request fields.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			run_q    <= in_data[0];
			dir_in_q <= in_data[1];
			target_q <= in_data[17:2];
		end
	end

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_PERIOD_RST;
			ramp_q   <= RAMP_PULSES_RST;
			revint_q <= REVERSE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START_PERIOD: start_q  <= cfg_wdata[PERIOD_W-1:0];
				REG_RAMP_PULSES:  ramp_q   <= cfg_wdata[RAMP_W-1:0];
				REG_REVERSE:      revint_q <= cfg_wdata[REV_W-1:0];
				default: ;
			endcase
		end
	end

	// Wanted direction and automatic reversal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q  <= '0;
			want_q <= 1'b0;
		end else if (cmd.rev_upd) begin
			if (revint_q == '0) begin
				rev_q  <= '0;
				want_q <= dir_in_q;
			end else if (rev_inc >= {1'b0, revint_q}) begin
				rev_q  <= '0;
				want_q <= ~want_q;
			end else begin
				rev_q <= rev_inc[REV_W-1:0];
			end
		end
	end

	// Motion state update, once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_STOPPED;
			period_q  <= '0;
			step_q    <= '0;
			rcount_q  <= '0;
			tick_q    <= '0;
			pulse_q   <= 1'b0;
			dir_now_q <= 1'b0;
		end else if (cmd.upd) begin
			case (mode_q)
				MODE_STOPPED: begin
					if (run_q) begin
						dir_now_q <= want_q;
						period_q  <= $signed({2'b00, start_q});
						step_q    <= div_res;
						rcount_q  <= '0;
						tick_q    <= '0;
						mode_q    <= MODE_ACCEL;
					end
				end
				MODE_ACCEL: begin
					if (toggle) begin
						tick_q   <= '0;
						pulse_q  <= ~pulse_q;
						period_q <= period_sat;
						if ((period_sat < $signed({2'b00, target_q})) || ramp_end) begin
							rcount_q <= '0;
							mode_q   <= MODE_RUN;
						end else begin
							rcount_q <= ramp_inc[RAMP_W-1:0];
						end
					end else begin
						tick_q <= tick_inc[PERIOD_W-1:0];
					end
				end
				MODE_RUN: begin
					if (leave_run) begin
						step_q   <= div_res;
						rcount_q <= '0;
						tick_q   <= '0;
						mode_q   <= MODE_DECEL;
					end else if (toggle) begin
						tick_q  <= '0;
						pulse_q <= ~pulse_q;
					end else begin
						tick_q <= tick_inc[PERIOD_W-1:0];
					end
				end
				default: begin
					if (toggle) begin
						tick_q   <= '0;
						pulse_q  <= ~pulse_q;
						period_q <= period_sat;
						if ((period_sat > $signed({2'b00, start_q})) || ramp_end) begin
							rcount_q <= '0;
							mode_q   <= MODE_STOPPED;
						end else begin
							rcount_q <= ramp_inc[RAMP_W-1:0];
						end
					end else begin
						tick_q <= tick_inc[PERIOD_W-1:0];
					end
				end
			endcase
		end
	end

	assign res.step_level      = pulse_q;
	assign res.direction_level = dir_now_q;
	assign res.driver_on       = (mode_q != MODE_STOPPED);
	assign res.motion_mode     = mode_q;

endmodule

// File: hdl/srpg_ctrl.sv
// Controller of the stepper ramp pulse generator: sequences one tick through
// direction update, optional step division, state update and result. Uses srpg_pkg.
module srpg_ctrl
	import srpg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  out_free,
	output logic  out_load,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REV  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		out_load      = 1'b0;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				if (in_valid) begin
					state_d = ST_REV;
				end
			end
			ST_REV: begin
				cmd.rev_upd = 1'b1;
				state_d     = ST_CHK;
			end
			ST_CHK: begin
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_UPD;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/stepper_ramp_pulse_generator.sv
// Top level of the stepper ramp pulse generator: stream ports, result register
// and assertions. Uses srpg_pkg, srpg_ctrl and srpg_dp.
//
// Each request is one timer tick and yields one result holding the step and
// direction pin levels, the driver enable and the motion mode. A tick passes
// through direction update, the optional step division, state update and
// the result register; on the ticks that start or stop a ramp the iterative
// divider produces the ramp step one quotient bit at a time, then applies the
// sign, adds one and clamps it, then hands it to the controller. A result waits
// in the controller until the result register is free, so a result that has
// not been taken holds up the next tick until it is taken. The next request is
// accepted as soon as the result has been registered, even if that result has
// not yet been taken.
module stepper_ramp_pulse_generator
	import srpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // run_request, direction, target_period[15:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // step_level, direction_level, driver_on, motion_mode[1:0], pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;
	res_t  res;
	logic  out_free;
	logic  out_load;
	logic  m_tvalid_q;
	res_t  m_res_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	srpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.out_load (out_load),
		.stat     (stat),
		.cmd      (cmd)
	);

	srpg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.res       (res)
	);

	// Result register between the datapath and the output stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_res_q};

	// A tick is accepted only while no other tick is in progress.
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while a tick is in progress");

	// The driver enable always agrees with the motion mode of a result.
	a_driver_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2] == (m_tdata[4:3] != MODE_STOPPED)))
		else $error("driver enable disagrees with motion mode");

	// A new result appears only when a tick has just finished.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result loaded without a finished tick");

endmodule
